@@ design/bsa_pkg.sv @@
// Shared constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int SLOT_W     = 12;
  localparam int FCOUNT_W   = 13;
  localparam int SLOT_SPACE = 4096;
  localparam int MODE_W     = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

@@ design/bsa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bitmap_slot_allocator_top.sv @@
// Bitmap slot allocator: usage map in RAM, lowest-free scan, free/test/mark.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | mode, slot
//  out     | out_valid/out_ready  | status, granted_slot, bit_value, free_count
//
// Allocate: after the accept cycle the map is read from word 0 upward until a
// word holds a free slot, or through the last word when the map is full; the RAM
// read port streams one word per cycle. Free/test/mark: the slot-to-word split
// runs in ST_DIV and ST_ADDR, then ST_RMW does the read-modify-write; a slot
// beyond the map is answered from ST_IDLE. A clearing pass after reset zeroes
// every map word with in_ready low. One request in flight; the next transfer
// is taken once the result register is empty or being drained.
module bitmap_slot_allocator_top #(
  parameter int MAP_BITS  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsa_pkg::MODE_W-1:0]    mode,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  output logic                          bit_value,
  output logic [bsa_pkg::FCOUNT_W-1:0]  free_count
);

  localparam int SW        = bsa_pkg::SLOT_W;
  localparam int FW        = bsa_pkg::FCOUNT_W;
  localparam int USABLE    = (MAP_BITS < bsa_pkg::SLOT_SPACE) ? MAP_BITS
                                                              : bsa_pkg::SLOT_SPACE;
  localparam int MAP_WORDS = (USABLE + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = USABLE - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
  localparam int QSH       = 16;
  localparam int RECIP     = (1 << QSH) / WORD_BITS;
  localparam int PW        = SW + QSH + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;

  logic [2:0]                 state, state_next;
  logic [AW-1:0]              clr_idx;
  logic [AW-1:0]              scan_idx;
  logic [AW-1:0]              word_q;
  logic [BW-1:0]              bit_q;
  logic [bsa_pkg::MODE_W-1:0] mode_q;
  logic [SW-1:0]              slot_q;
  logic [FW-1:0]              free_slots, free_slots_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic                 accept;
  logic [PW-1:0]        prod;
  logic [SW-1:0]        rem;
  logic [AW-1:0]        word_c;
  logic [BW-1:0]        bit_c;
  logic [WORD_BITS-1:0] avail, onehot, bit_mask;
  logic [BW-1:0]        enc;
  logic                 cur_bit;

  logic          done;
  logic          res_status;
  logic [SW-1:0] res_granted;
  logic          res_bit;

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(AW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // slot / WORD_BITS by reciprocal; estimate is exact or one low
  assign prod = PW'(slot_q) * PW'(RECIP);

  always_comb begin
    rem = slot_q - SW'(SW'(word_q) * SW'(WORD_BITS));
    if (rem >= SW'(WORD_BITS)) begin
      word_c = AW'(word_q + 1'b1);
      bit_c  = BW'(rem - SW'(WORD_BITS));
    end else begin
      word_c = word_q;
      bit_c  = BW'(rem);
    end
  end

  always_comb begin
    avail  = ~ram_rdata & ((scan_idx == LAST_WORD) ? LAST_MASK : {WORD_BITS{1'b1}});
    onehot = avail & (~avail + 1'b1);
    enc    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        enc = enc | BW'(i);
      end
    end
  end

  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_q;
  assign cur_bit  = |(ram_rdata & bit_mask);

  always_comb begin
    state_next      = state;
    free_slots_next = free_slots;
    ram_we          = 1'b0;
    ram_waddr       = scan_idx;
    ram_wdata       = ram_rdata;
    ram_raddr       = '0;
    done            = 1'b0;
    res_status      = bsa_pkg::STATUS_OK;
    res_granted     = '0;
    res_bit         = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (mode == bsa_pkg::MODE_ALLOC) begin
            state_next = ST_SCAN;
          end else if (32'(slot) < USABLE) begin
            state_next = ST_DIV;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_DIV: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        ram_raddr  = word_c;
        state_next = ST_RMW;
      end
      ST_RMW: begin
        ram_waddr = word_q;
        res_bit   = cur_bit;
        done      = 1'b1;
        state_next = ST_IDLE;
        if (mode_q == bsa_pkg::MODE_FREE && cur_bit) begin
          ram_we          = 1'b1;
          ram_wdata       = ram_rdata & ~bit_mask;
          free_slots_next = FW'(free_slots + 1'b1);
        end else if (mode_q == bsa_pkg::MODE_MARK && !cur_bit) begin
          ram_we          = 1'b1;
          ram_wdata       = ram_rdata | bit_mask;
          free_slots_next = FW'(free_slots - 1'b1);
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(scan_idx + 1'b1);
        ram_waddr = scan_idx;
        if (|avail) begin
          ram_we          = 1'b1;
          ram_wdata       = ram_rdata | onehot;
          free_slots_next = FW'(free_slots - 1'b1);
          res_granted     = SW'(SW'(scan_idx) * SW'(WORD_BITS)) + SW'(enc);
          done            = 1'b1;
          state_next      = ST_IDLE;
        end else if (scan_idx == LAST_WORD) begin
          res_status = bsa_pkg::STATUS_FULL;
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      free_slots <= FW'(USABLE);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_slots <= free_slots_next;
      if (state == ST_CLEAR) begin
        clr_idx <= AW'(clr_idx + 1'b1);
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q   <= mode;
      slot_q   <= slot;
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= AW'(scan_idx + 1'b1);
    end
    if (state == ST_DIV) begin
      word_q <= AW'(prod >> QSH);
    end else if (state == ST_ADDR) begin
      word_q <= word_c;
      bit_q  <= bit_c;
    end
    if (done) begin
      status       <= res_status;
      granted_slot <= res_granted;
      bit_value    <= res_bit;
      free_count   <= free_slots_next;
    end
  end

endmodule

@@ sim/bitmap_slot_allocator_checker.sv @@
// Checker for the bitmap slot allocator: tracks the usage map and compares every reply.
`timescale 1ns / 1ps

module bitmap_slot_allocator_checker #(
  parameter int MAP_BITS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [bsa_pkg::MODE_W-1:0]    mode,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          status,
  input  logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  input  logic                          bit_value,
  input  logic [bsa_pkg::FCOUNT_W-1:0]  free_count,
  output int                            mismatches,
  output int                            outstanding,
  output int                            replies_seen,
  output int                            full_replies
);
  import bsa_pkg::*;

  localparam int USABLE = (MAP_BITS < SLOT_SPACE) ? MAP_BITS : SLOT_SPACE;

  typedef struct packed {
    logic                status;
    logic [SLOT_W-1:0]   granted;
    logic                bitv;
    logic [FCOUNT_W-1:0] free_cnt;
  } reply_t;

  bit [SLOT_SPACE-1:0] used_map;
  logic [FCOUNT_W-1:0] free_left;
  reply_t              pending_replies[$];
  int                  bad;
  int                  seen;
  int                  fulls;

  function automatic reply_t apply_request(input logic [MODE_W-1:0] m,
                                           input logic [SLOT_W-1:0] s);
    reply_t r;
    logic   hit;
    r   = '0;
    hit = 1'b0;
    if (m == MODE_ALLOC) begin
      for (int i = 0; i < USABLE; i++) begin
        if (!hit && !used_map[i]) begin
          hit       = 1'b1;
          r.granted = SLOT_W'(i);
        end
      end
      if (hit) begin
        used_map[r.granted] = 1'b1;
        if (free_left != 0) free_left = free_left - 1'b1;
      end else begin
        r.status = STATUS_FULL;
      end
    end else if (s < USABLE) begin
      r.bitv = used_map[s];
      if (m == MODE_FREE && r.bitv) begin
        used_map[s] = 1'b0;
        if (free_left < USABLE) free_left = free_left + 1'b1;
      end else if (m == MODE_MARK && !r.bitv) begin
        used_map[s] = 1'b1;
        if (free_left != 0) free_left = free_left - 1'b1;
      end
    end
    r.free_cnt = free_left;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      used_map  = '0;
      free_left = FCOUNT_W'(USABLE);
      pending_replies.delete();
      bad   = 0;
      seen  = 0;
      fulls = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, granted_slot, bit_value, free_count};
        if (pending_replies.size() == 0) begin
          if (bad < 10)
            $display("MISMATCH: unexpected reply status=%0d slot=%0d bit=%0d free=%0d",
                     got.status, got.granted, got.bitv, got.free_cnt);
          bad++;
        end else begin
          want = pending_replies.pop_front();
          if (got !== want) begin
            if (bad < 10) begin
              $display("MISMATCH reply %0d: expected status=%0d slot=%0d bit=%0d free=%0d",
                       seen, want.status, want.granted, want.bitv, want.free_cnt);
              $display("  got status=%0d slot=%0d bit=%0d free=%0d",
                       got.status, got.granted, got.bitv, got.free_cnt);
            end
            bad++;
          end
          if (want.status == STATUS_FULL) fulls++;
          seen++;
        end
      end
      if (in_valid && in_ready) pending_replies.push_back(apply_request(mode, slot));
    end
    mismatches   <= bad;
    outstanding  <= pending_replies.size();
    replies_seen <= seen;
    full_replies <= fulls;
  end

endmodule

@@ sim/bitmap_slot_allocator_top_tb.sv @@
// Testbench top for the bitmap slot allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_slot_allocator_top_tb;
  import bsa_pkg::*;

  localparam int MAP_BITS    = 4096;
  localparam int WORD_BITS   = 64;
  localparam int HOLD_START  = 3000;
  localparam int HOLD_LEN    = 400;
  localparam int STEADY_FROM = 4500;
  localparam int STEADY_TO   = 6500;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode      = MODE_TEST;
  logic [SLOT_W-1:0]   slot      = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                status;
  logic [SLOT_W-1:0]   granted_slot;
  logic                bit_value;
  logic [FCOUNT_W-1:0] free_count;

  int mismatches;
  int outstanding;
  int replies_seen;
  int full_replies;
  int sent;
  int rx_cycle;
  bit steady_tx;

  bitmap_slot_allocator_top #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_slot (granted_slot),
    .bit_value    (bit_value),
    .free_count   (free_count)
  );

  bitmap_slot_allocator_checker #(
    .MAP_BITS (MAP_BITS)
  ) CHK (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_slot (granted_slot),
    .bit_value    (bit_value),
    .free_count   (free_count),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .replies_seen (replies_seen),
    .full_replies (full_replies)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random backpressure, one long hold-off, one stretch always ready
  always @(posedge clk) begin
    if (rst) begin
      rx_cycle  <= 0;
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
        out_ready <= 1'b0;
      else if (rx_cycle >= STEADY_FROM && rx_cycle < STEADY_TO)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 28);
    end
  end

  task automatic offer(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s);
    if (!steady_tx && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 28) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    slot     <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int                pick;
    logic [MODE_W-1:0] m;
    logic [SLOT_W-1:0] s;
    sent      = 0;
    steady_tx = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, holes, double free/mark, word edges, top slot
    offer(MODE_ALLOC, 12'hFFF);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_TEST,  12'd0);
    offer(MODE_FREE,  12'd1);
    offer(MODE_FREE,  12'd1);
    offer(MODE_TEST,  12'd1);
    offer(MODE_MARK,  12'hFFF);
    offer(MODE_MARK,  12'hFFF);
    offer(MODE_TEST,  12'hFFF);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_MARK,  12'd2);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_MARK,  12'd63);
    offer(MODE_MARK,  12'd64);
    offer(MODE_TEST,  12'd64);
    offer(MODE_FREE,  12'd0);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_TEST,  12'hAAA);
    offer(MODE_TEST,  12'h555);
    offer(MODE_FREE,  12'hFFF);
    offer(MODE_TEST,  12'hFFF);
    drain();

    // random, mostly around the low slots that allocate hands out
    for (int n = 0; n < 600; n++) begin
      steady_tx = (n >= 350 && n < 520);
      pick = $urandom_range(99);
      m = (pick < 35) ? MODE_ALLOC : (pick < 60) ? MODE_FREE :
          (pick < 75) ? MODE_TEST : MODE_MARK;
      s = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(511))
                                    : SLOT_W'($urandom_range(SLOT_SPACE - 1));
      offer(m, s);
    end
    steady_tx = 1'b0;
    drain();

    // load up the low words so scans get longer, then a few edge requests
    repeat (400) offer(MODE_ALLOC, SLOT_W'($urandom_range(SLOT_SPACE - 1)));
    offer(MODE_TEST,  12'hFFF);
    offer(MODE_FREE,  12'hFFF);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_FREE,  12'd0);
    offer(MODE_FREE,  12'd4000);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_ALLOC, 12'h000);
    offer(MODE_MARK,  12'd17);
    offer(MODE_FREE,  12'd17);
    offer(MODE_FREE,  12'd17);
    drain();

    // random churn on a well-used map: holes anywhere, long scans
    for (int n = 0; n < 420; n++) begin
      pick = $urandom_range(99);
      m = (pick < 35) ? MODE_FREE : (pick < 70) ? MODE_ALLOC :
          (pick < 85) ? MODE_TEST : MODE_MARK;
      offer(m, SLOT_W'($urandom_range(SLOT_SPACE - 1)));
    end
    drain();
    repeat (100) @(posedge clk);

    $display("Run covered %0d requests and %0d checked replies, %0d of them full-map allocates.",
             sent, replies_seen, full_replies);
    $display("Mismatches counted: %0d", mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
design/bsa_pkg.sv
design/bsa_ram.sv
design/bitmap_slot_allocator_top.sv
sim/bitmap_slot_allocator_checker.sv
sim/bitmap_slot_allocator_top_tb.sv
